// ===== rtl/plob_pkg.sv =====
`default_nettype none
package plob_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ID_W   = 10;
  localparam int unsigned PX_W   = 12;
  localparam int unsigned QIN_W  = 32;
  localparam int unsigned RES_W  = 42;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned LOC_W  = 11;

  // Book dimensions; the request fields are sized to match them exactly.
  localparam int unsigned MAX_ORDERS  = 1024;
  localparam int unsigned PRICE_TICKS = 4096;
  localparam int unsigned QTY_BITS    = 32;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LEVEL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIQ    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;

  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ORD_RD,
    S_ORD_WAIT,
    S_LVL_RD,
    S_LVL_WAIT,
    S_LVL_WR,
    S_SCAN_RD,
    S_SCAN_ACC,
    S_BEST,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/plob_if.sv =====
`default_nettype none
interface plob_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [9:0]  slot_id;
  logic        side;
  logic [11:0] price;
  logic [31:0] quantity;
  modport source (output valid, command, slot_id, side, price, quantity, input ready);
  modport sink   (input valid, command, slot_id, side, price, quantity, output ready);
endinterface

interface plob_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [41:0] quantity_result;
  logic        best_bid_valid;
  logic [11:0] best_bid;
  logic        best_ask_valid;
  logic [11:0] best_ask;
  logic [12:0] bid_level_count;
  logic [12:0] ask_level_count;
  modport source (output valid, status, quantity_result, best_bid_valid, best_bid,
                  best_ask_valid, best_ask, bid_level_count, ask_level_count, input ready);
  modport sink   (input valid, status, quantity_result, best_bid_valid, best_bid,
                  best_ask_valid, best_ask, bid_level_count, ask_level_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/price_level_order_book_core.sv =====
`default_nettype none
// Price-level limit order book core.
// Requests arrive on a valid/ready channel (plob_in_if): add, cancel, level query
// and liquidity query. Each request yields exactly one result on the output
// channel (plob_out_if) carrying a status, a quantity and the book summary.
// Order slots (with their live flag) live in one RAM, level totals and order
// counts in a second RAM indexed by side and price tick, and the per-tick
// occupancy bitmaps of both sides in a third RAM, one 64-tick word per entry.
// A small sequencer drives one shared saturating adder/subtractor over them.
// Add and cancel read and update the order RAM, then read and write back the level
// RAM and its bitmap bit; a level query reads both RAMs and writes neither, and a
// rejected add or cancel reads only the order RAM. A liquidity query walks every
// tick of one side through the level RAM. Every request then finds the best bid and
// best ask by reading the bitmap words, one per cycle. The block is ready again in
// the cycle after the result leaves.
// At reset a clearing pass zeroes all three RAMs, one entry of each per cycle,
// so the block accepts nothing until the pass ends. The result is held in
// an output register until taken; a stalled receiver holds the block, which
// takes no new request until the result leaves.
module price_level_order_book_core (
  input wire logic clk,
  input wire logic rst,
  plob_in_if.sink    req,
  plob_out_if.source rsp
);
  import plob_pkg::*;

  localparam int unsigned OID_W  = $clog2(MAX_ORDERS);
  localparam int unsigned TPX_W  = $clog2(PRICE_TICKS);
  localparam int unsigned LVL_W  = TPX_W + 1;
  localparam int unsigned LVLS   = 2 * PRICE_TICKS;
  localparam int unsigned ORD_DW = 2 + TPX_W + QTY_BITS;
  localparam int unsigned LVL_DW = RES_W + LOC_W;
  localparam int unsigned SCAN_W = 64;
  localparam int unsigned WORDS  = PRICE_TICKS / SCAN_W;
  localparam int unsigned WRD_W  = $clog2(WORDS);
  localparam int unsigned SB_W   = $clog2(SCAN_W);

  state_t state, state_next;

  // Request registers.
  logic [CMD_W-1:0]    cmd;
  logic [OID_W-1:0]    oid;
  logic                sd;
  logic [TPX_W-1:0]    px;
  logic [QTY_BITS-1:0] qty;

  logic [CNT_W-1:0]    bid_used, ask_used;

  // Order RAM: live flag, side, price and quantity of each slot.
  logic                ord_we;
  logic [OID_W-1:0]    ord_waddr;
  logic [ORD_DW-1:0]   ord_wdata, ord_rdata;
  logic                o_live;
  logic                o_sd;
  logic [TPX_W-1:0]    o_px;
  logic [QTY_BITS-1:0] o_q;
  assign {o_live, o_sd, o_px, o_q} = ord_rdata;

  plob_ram #(.WIDTH(ORD_DW), .DEPTH(MAX_ORDERS)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(oid), .rdata(ord_rdata)
  );

  // Level RAM.
  logic              lvl_we;
  logic [LVL_W-1:0]  lvl_waddr, lvl_raddr, lvl_addr;
  logic [LVL_DW-1:0] lvl_wdata, lvl_rdata;
  logic [RES_W-1:0]  l_tot;
  logic [LOC_W-1:0]  l_cnt;
  assign {l_tot, l_cnt} = lvl_rdata;

  plob_ram #(.WIDTH(LVL_DW), .DEPTH(LVLS)) u_lvl (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(lvl_raddr), .rdata(lvl_rdata)
  );

  // Occupancy RAM: ask bits in the upper half of each word, bid bits in the lower.
  logic                occ_we;
  logic [WRD_W-1:0]    occ_waddr, occ_raddr;
  logic [2*SCAN_W-1:0] occ_wdata, occ_rdata;
  logic [SCAN_W-1:0]   bw, aw;
  assign {aw, bw} = occ_rdata;

  plob_ram #(.WIDTH(2 * SCAN_W), .DEPTH(WORDS)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(occ_raddr), .rdata(occ_rdata)
  );

  logic [LVL_W-1:0] ctr;       // clearing / liquidity walk counter
  logic [WRD_W-1:0] wctr;      // best-price scan word being addressed
  logic [WRD_W-1:0] dw;        // scan word whose data is on the RAM output
  logic             dv;        // the RAM output holds a scan word
  logic [RES_W-1:0] acc;
  logic [1:0]       stat;
  logic             bbv, bav;
  logic [TPX_W-1:0] bb, ba;

  // Shared saturating add/subtract unit.
  logic              alu_sub;
  logic [RES_W-1:0]  alu_a, alu_b, alu_y;
  logic [RES_W:0]    alu_sum;
  always_comb begin
    if (alu_sub) begin
      alu_y = (alu_a >= alu_b) ? alu_a - alu_b : '0;
      alu_sum = '0;
    end else begin
      alu_sum = {1'b0, alu_a} + {1'b0, alu_b};
      alu_y = alu_sum[RES_W] ? RES_MAX : alu_sum[RES_W-1:0];
    end
  end

  // Side and price of the level being touched by add or cancel.
  logic             t_sd;
  logic [TPX_W-1:0] t_px;
  assign t_sd = (cmd == CMD_CANCEL) ? o_sd : sd;
  assign t_px = (cmd == CMD_CANCEL) ? o_px : px;
  assign lvl_addr = {t_sd, t_px};

  // Highest set bid bit and lowest set ask bit of the word on the RAM output.
  logic              bw_hit, aw_hit;
  logic [SB_W-1:0]   bw_top, aw_low;
  always_comb begin
    bw_hit = 1'b0;
    aw_hit = 1'b0;
    bw_top = '0;
    aw_low = '0;
    for (int i = 0; i < SCAN_W; i++) begin
      if (bw[i]) begin
        bw_hit = 1'b1;
        bw_top = SB_W'(i);
      end
    end
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (aw[i]) begin
        aw_hit = 1'b1;
        aw_low = SB_W'(i);
      end
    end
  end

  logic in_range;
  assign in_range = sd ? (ctr[TPX_W-1:0] <= px) : (ctr[TPX_W-1:0] >= px);

  logic [LOC_W-1:0] cnt_new;
  logic             lvl_empty_after;

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ord_we    = 1'b0;
    ord_waddr = oid;
    ord_wdata = {1'b1, sd, px, qty};
    lvl_we    = 1'b0;
    lvl_waddr = lvl_addr;
    lvl_wdata = '0;
    lvl_raddr = lvl_addr;
    occ_we    = 1'b0;
    occ_waddr = lvl_addr[TPX_W-1:SB_W];
    occ_raddr = lvl_addr[TPX_W-1:SB_W];
    occ_wdata = occ_rdata;
    alu_sub   = 1'b0;
    alu_a     = l_tot;
    alu_b     = RES_W'(qty);
    cnt_new   = l_cnt;
    lvl_empty_after = 1'b0;
    case (state)
      S_CLEAR: begin
        lvl_we    = 1'b1;
        lvl_waddr = ctr;
        ord_we    = (ctr < LVL_W'(MAX_ORDERS));
        ord_waddr = ctr[OID_W-1:0];
        ord_wdata = '0;
        occ_we    = (ctr < LVL_W'(WORDS));
        occ_waddr = ctr[WRD_W-1:0];
        occ_wdata = '0;
        if (ctr == LVL_W'(LVLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_ORD_RD;
        end
      end
      S_ORD_RD: state_next = S_ORD_WAIT;
      S_ORD_WAIT: begin
        case (cmd)
          CMD_ADD: begin
            if (o_live) begin
              state_next = S_BEST;
            end else begin
              ord_we     = 1'b1;
              state_next = S_LVL_RD;
            end
          end
          CMD_CANCEL: begin
            if (o_live) begin
              ord_we     = 1'b1;
              ord_wdata  = {1'b0, o_sd, o_px, o_q};
              state_next = S_LVL_RD;
            end else begin
              state_next = S_BEST;
            end
          end
          CMD_LEVEL: state_next = S_LVL_RD;
          default:   state_next = S_SCAN_RD;
        endcase
      end
      S_LVL_RD: state_next = S_LVL_WAIT;
      S_LVL_WAIT: begin
        state_next = (cmd == CMD_LEVEL) ? S_BEST : S_LVL_WR;
      end
      S_LVL_WR: begin
        lvl_we = 1'b1;
        if (cmd == CMD_ADD) begin
          cnt_new   = l_cnt + 1'b1;
          lvl_wdata = {alu_y, cnt_new};
        end else begin
          alu_sub = 1'b1;
          alu_b   = RES_W'(o_q);
          cnt_new = (l_cnt != '0) ? l_cnt - 1'b1 : l_cnt;
          lvl_empty_after = (cnt_new == '0);
          lvl_wdata = {(lvl_empty_after ? {RES_W{1'b0}} : alu_y), cnt_new};
        end
        // The touched level's bitmap bit follows its order count.
        occ_we = 1'b1;
        occ_wdata[{t_sd, t_px[SB_W-1:0]}] = (cnt_new != '0);
        state_next = S_BEST;
      end
      S_SCAN_RD: begin
        lvl_raddr  = {sd, ctr[TPX_W-1:0]};
        state_next = S_SCAN_ACC;
      end
      S_SCAN_ACC: begin
        alu_a = acc;
        alu_b = l_tot;
        state_next = (ctr == LVL_W'(PRICE_TICKS - 1)) ? S_BEST : S_SCAN_RD;
      end
      S_BEST: begin
        occ_raddr = wctr;
        if (dv && dw == WRD_W'(WORDS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_used <= '0;
      ask_used <= '0;
      ctr      <= '0;
      wctr     <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          ctr <= ctr + 1'b1;
        end
        S_IDLE: begin
          cmd  <= req.command;
          oid  <= req.slot_id;
          sd   <= req.side;
          px   <= req.price;
          qty  <= req.quantity;
          acc  <= '0;
          stat <= ST_OK;
          ctr  <= '0;
          wctr <= '0;
          dw   <= '0;
          dv   <= 1'b0;
          bbv  <= 1'b0;
          bav  <= 1'b0;
          bb   <= '0;
          ba   <= '0;
        end
        S_ORD_WAIT: begin
          if (cmd == CMD_ADD && o_live) begin
            stat <= ST_DUP;
          end
          if (cmd == CMD_CANCEL && !o_live) begin
            stat <= ST_NOT_FOUND;
          end
        end
        S_LVL_WAIT: begin
          if (cmd == CMD_LEVEL) begin
            acc <= (l_cnt != '0) ? l_tot : '0;
          end
        end
        S_LVL_WR: begin
          if (cmd == CMD_ADD) begin
            if (l_cnt == '0) begin
              if (sd) begin
                ask_used <= ask_used + 1'b1;
              end else begin
                bid_used <= bid_used + 1'b1;
              end
            end
          end else if (lvl_empty_after) begin
            if (o_sd) begin
              if (ask_used != '0) ask_used <= ask_used - 1'b1;
            end else begin
              if (bid_used != '0) bid_used <= bid_used - 1'b1;
            end
          end
        end
        S_SCAN_ACC: begin
          if (l_cnt != '0 && in_range) begin
            acc <= alu_y;
          end
          ctr <= ctr + 1'b1;
        end
        S_BEST: begin
          // The RAM output is registered, so it lags the word address.
          dv <= 1'b1;
          dw <= wctr;
          if (wctr != WRD_W'(WORDS - 1)) begin
            wctr <= wctr + 1'b1;
          end
          // Bids keep the highest word seen; asks keep the first.
          if (dv) begin
            if (bw_hit) begin
              bbv <= 1'b1;
              bb  <= {dw, bw_top};
            end
            if (aw_hit && !bav) begin
              bav <= 1'b1;
              ba  <= {dw, aw_low};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.valid           = (state == S_OUT);
  assign rsp.status          = stat;
  assign rsp.quantity_result = acc;
  assign rsp.best_bid_valid  = bbv;
  assign rsp.best_bid        = PX_W'(bb);
  assign rsp.best_ask_valid  = bav;
  assign rsp.best_ask        = PX_W'(ba);
  assign rsp.bid_level_count = bid_used;
  assign rsp.ask_level_count = ask_used;

  // A result leaves only after the request was taken and is held while stalled.
  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(acc))
    else $error("result dropped under stall");
  a_best_valid: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (bbv == (bid_used != '0)) && (bav == (ask_used != '0)))
    else $error("best price flag disagrees with level count");
  a_status_q: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && stat != ST_OK |-> acc == '0) else $error("rejected request has quantity");

endmodule
`default_nettype wire

// ===== rtl/plob_ram.sv =====
`default_nettype none
module plob_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== verif/tb_price_level_order_book_core.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_price_level_order_book_core;
  import plob_pkg::*;

  localparam int unsigned NUM_IDS   = MAX_ORDERS;
  localparam int unsigned NUM_TICKS = PRICE_TICKS;

  // One book summary and answer, as the block reports it for every request.
  typedef struct packed {
    logic [1:0]       status;
    logic [RES_W-1:0] quantity_result;
    logic             best_bid_valid;
    logic [PX_W-1:0]  best_bid;
    logic             best_ask_valid;
    logic [PX_W-1:0]  best_ask;
    logic [CNT_W-1:0] bid_level_count;
    logic [CNT_W-1:0] ask_level_count;
  } book_answer_t;

  logic clk;
  logic rst;

  plob_in_if  req ();
  plob_out_if rsp ();

  price_level_order_book_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // Shadow copy of the book, kept by the testbench alone.
  bit               slot_live [NUM_IDS];
  bit               slot_side [NUM_IDS];
  logic [PX_W-1:0]  slot_price [NUM_IDS];
  logic [QIN_W-1:0] slot_qty [NUM_IDS];
  logic [RES_W-1:0] tick_total [2][NUM_TICKS];
  int unsigned      tick_orders [2][NUM_TICKS];
  int unsigned      levels_used [2];

  book_answer_t answers_due [$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned answers_seen;
  int unsigned requests_sent;
  int unsigned liq_sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [RES_W-1:0] sat_sum(logic [RES_W-1:0] a, logic [RES_W-1:0] b);
    logic [RES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RES_W] ? RES_MAX : s[RES_W-1:0];
  endfunction

  // Applies one request to the shadow book and works out the answer the block owes.
  function automatic book_answer_t apply_request(logic [1:0] cmd, logic [ID_W-1:0] id,
                                                 logic sd, logic [PX_W-1:0] px,
                                                 logic [QIN_W-1:0] qty);
    book_answer_t a;
    int unsigned  s;
    int unsigned  p;
    a = '0;
    case (cmd)
      CMD_ADD: begin
        if (slot_live[id]) begin
          a.status = ST_DUP;
        end else begin
          slot_live[id]  = 1'b1;
          slot_side[id]  = sd;
          slot_price[id] = px;
          slot_qty[id]   = qty;
          if (tick_orders[sd][px] == 0) levels_used[sd]++;
          tick_orders[sd][px]++;
          tick_total[sd][px] = sat_sum(tick_total[sd][px], RES_W'(qty));
        end
      end
      CMD_CANCEL: begin
        if (!slot_live[id]) begin
          a.status = ST_NOT_FOUND;
        end else begin
          s = 32'(slot_side[id]);
          p = 32'(slot_price[id]);
          tick_total[s][p] = (tick_total[s][p] >= RES_W'(slot_qty[id])) ?
                             tick_total[s][p] - RES_W'(slot_qty[id]) : '0;
          tick_orders[s][p]--;
          if (tick_orders[s][p] == 0) begin
            tick_total[s][p] = '0;
            levels_used[s]--;
          end
          slot_live[id] = 1'b0;
        end
      end
      CMD_LEVEL: begin
        if (tick_orders[sd][px] != 0) a.quantity_result = tick_total[sd][px];
      end
      default: begin
        for (p = 0; p < NUM_TICKS; p++) begin
          if (tick_orders[sd][p] != 0 && (sd ? (p <= px) : (p >= px)))
            a.quantity_result = sat_sum(a.quantity_result, tick_total[sd][p]);
        end
      end
    endcase
    for (p = 0; p < NUM_TICKS; p++) begin
      if (tick_orders[0][p] != 0) begin
        a.best_bid_valid = 1'b1;
        a.best_bid = PX_W'(p);
      end
      if (!a.best_ask_valid && tick_orders[1][p] != 0) begin
        a.best_ask_valid = 1'b1;
        a.best_ask = PX_W'(p);
      end
    end
    a.bid_level_count = CNT_W'(levels_used[0]);
    a.ask_level_count = CNT_W'(levels_used[1]);
    return a;
  endfunction

  // Sends one request, idling beforehand at the current rate, and records the answer due.
  // It returns at the falling edge after acceptance with valid still high; the next
  // request takes it over or drops it while idling, or the drain that follows takes it down.
  task automatic send_request(logic [1:0] cmd, logic [ID_W-1:0] id, logic sd,
                              logic [PX_W-1:0] px, logic [QIN_W-1:0] qty);
    book_answer_t due;
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid    <= 1'b1;
    req.command  <= cmd;
    req.slot_id  <= id;
    req.side     <= sd;
    req.price    <= px;
    req.quantity <= qty;
    do @(posedge clk); while (!req.ready);
    due = apply_request(cmd, id, sd, px, qty);
    answers_due = {answers_due, due};
    requests_sent++;
    if (cmd == CMD_LIQ) liq_sent++;
    @(negedge clk);
  endtask

  // Receiver with random stalls.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Each answer taken is held against the oldest one due.
  always @(posedge clk) begin
    book_answer_t got;
    book_answer_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.quantity_result, rsp.best_bid_valid, rsp.best_bid,
             rsp.best_ask_valid, rsp.best_ask, rsp.bid_level_count, rsp.ask_level_count};
      answers_seen++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %p", got);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("answer %0d: expected %p, got %p",
                                         answers_seen, want, got);
        end
      end
    end
  end

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Edges of every field and each special case: duplicate add, cancel of a free slot,
  // zero-quantity add, absent level and a level shared by several large orders.
  // Saturation cannot be reached: all slots at full quantity stay below 2^42-1.
  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    send_request(CMD_LEVEL, 10'd0, 1'b0, 12'd0, '0);
    send_request(CMD_CANCEL, 10'd5, 1'b0, 12'd0, '0);
    send_request(CMD_ADD, 10'd0, 1'b0, 12'd0, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 10'd0, 1'b1, 12'd7, 32'd1);
    send_request(CMD_ADD, 10'd1023, 1'b1, 12'd4095, 32'hFFFF_FFFF);
    send_request(CMD_ADD, 10'd2, 1'b1, 12'd0, 32'd0);
    send_request(CMD_ADD, 10'd3, 1'b0, 12'd4095, 32'hAAAA_5555);
    send_request(CMD_LEVEL, 10'd0, 1'b1, 12'd0, '0);
    send_request(CMD_LIQ, 10'd0, 1'b1, 12'd4095, '0);
    send_request(CMD_LIQ, 10'd0, 1'b0, 12'd0, '0);
    // Several maximal orders share one bid tick.
    for (int i = 4; i < 12; i++)
      send_request(CMD_ADD, i[ID_W-1:0], 1'b0, 12'd100, 32'hFFFF_FFFF);
    send_request(CMD_LEVEL, 10'd0, 1'b0, 12'd100, '0);
    send_request(CMD_LIQ, 10'd0, 1'b0, 12'd100, '0);
    send_request(CMD_LIQ, 10'd0, 1'b1, 12'd0, '0);
    send_request(CMD_CANCEL, 10'd6, 1'b0, 12'd0, '0);
    send_request(CMD_LEVEL, 10'd0, 1'b0, 12'd100, '0);
    for (int i = 0; i < NUM_IDS; i++)
      if (slot_live[i]) send_request(CMD_CANCEL, i[ID_W-1:0], 1'b0, 12'd0, '0);
    send_request(CMD_CANCEL, 10'd1023, 1'b0, 12'd0, '0);
    send_request(CMD_LEVEL, 10'd0, 1'b1, 12'd4095, '0);
    send_request(CMD_LIQ, 10'd0, 1'b1, 12'd4095, '0);
    wait_drained();
  endtask

  // Random requests, mostly adds and cancels on a narrow band of ticks and ids so that
  // levels fill, share orders and empty; liquidity queries are kept rare as they are slow.
  task automatic test_random(int unsigned count, int unsigned idle, int unsigned stall);
    int unsigned      r;
    logic [ID_W-1:0]  id;
    logic [ID_W-1:0]  any_id;
    logic [PX_W-1:0]  px;
    logic [QIN_W-1:0] qty;
    logic [QIN_W-1:0] any_qty;
    logic             sd;
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      r  = $urandom_range(99);
      id = ($urandom_range(3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(63));
      px = ($urandom_range(3) == 0) ? PX_W'($urandom) : PX_W'(2000 + $urandom_range(15));
      qty = ($urandom_range(7) == 0) ? QIN_W'($urandom) : QIN_W'($urandom_range(1000));
      sd = 1'($urandom);
      any_id = ID_W'($urandom);
      any_qty = QIN_W'($urandom);
      if (r < 45)      send_request(CMD_ADD, id, sd, px, qty);
      else if (r < 80) send_request(CMD_CANCEL, id, sd, px, any_qty);
      else if (r < 96) send_request(CMD_LEVEL, any_id, sd, px, any_qty);
      else             send_request(CMD_LIQ, any_id, sd, px, any_qty);
    end
    wait_drained();
  endtask

  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.command = CMD_ADD;
    req.slot_id = '0;
    req.side = 1'b0;
    req.price = '0;
    req.quantity = '0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    answers_seen = 0;
    requests_sent = 0;
    liq_sent = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(115, 0, 0);
    test_random(115, 63, 0);
    test_random(115, 0, 63);
    test_random(115, 18, 18);
    $display("Covered %0d requests (%0d liquidity sweeps), %0d answers checked, %0d wrong.",
             requests_sent, liq_sent, answers_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
